>>> src/bcd_pkg.sv
// Package for the BC1/BC2/BC3 block decoder: item types, format codes,
// register map and the reciprocal constants used for the exact rounding.
// No dependencies.
package bcd_pkg;

  typedef enum logic [1:0] {
    FMT_BC1  = 2'd0,
    FMT_BC2  = 2'd1,
    FMT_BC3  = 2'd2,
    FMT_BC3X = 2'd3   // decoded as BC3
  } format_e;

  // APB register map
  localparam int unsigned AddrW   = 3;
  localparam int unsigned RegIdxW = 1;
  localparam logic [RegIdxW-1:0] REG_FORMAT = 1'b0;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [63:0] alpha_bits;
    logic [63:0] color_bits;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [3:0] pixel_index;
    logic       last_pixel;
  } out_item_t;

  typedef struct packed {
    logic bc1;    // color palette alpha
    logic bc3;    // interpolated alpha (else explicit when not bc1)
    logic three;  // BC1 three-color + transparent black
    logic a_gt;   // alpha0 > alpha1: eight-level alpha
  } mode_t;

  // classified block between front and back
  typedef struct packed {
    mode_t       mode;
    logic [15:0] e0;
    logic [15:0] e1;
    logic [31:0] cidx;
    logic [63:0] abits;
  } blk_t;

  typedef struct packed {
    logic [3:0][2:0][7:0] col;   // [entry][r,g,b]
    logic [7:0][7:0]      apal;
  } pal_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] cidx;
    logic [63:0] abits;
    pal_t        pal;
  } pblk_t;

  // round(n/d) = floor(N * R >> S), N = 2n + d, R = ceil(2^S / 2d);
  // exact while N * 2d <= 2^S.
  localparam int unsigned ColShift = 26;
  localparam int unsigned ColNW    = 17;
  localparam int unsigned ColRW    = 21;
  localparam int unsigned AlpShift = 16;
  localparam int unsigned AlpNW    = 12;
  localparam int unsigned AlpRW    = 13;

  localparam logic [ColRW-1:0] RCP_D31  = ColRW'((2**ColShift + 61) / 62);
  localparam logic [ColRW-1:0] RCP_D62  = ColRW'((2**ColShift + 123) / 124);
  localparam logic [ColRW-1:0] RCP_D93  = ColRW'((2**ColShift + 185) / 186);
  localparam logic [ColRW-1:0] RCP_D63  = ColRW'((2**ColShift + 125) / 126);
  localparam logic [ColRW-1:0] RCP_D126 = ColRW'((2**ColShift + 251) / 252);
  localparam logic [ColRW-1:0] RCP_D189 = ColRW'((2**ColShift + 377) / 378);

  localparam logic [AlpRW-1:0] RCP_A7 = AlpRW'((2**AlpShift + 13) / 14);
  localparam logic [AlpRW-1:0] RCP_A5 = AlpRW'((2**AlpShift + 9) / 10);

  // numerator that yields 255 under the divide-by-5 reciprocal
  localparam logic [AlpNW-1:0] ALP_N_FULL = AlpNW'(2 * 5 * 255);

endpackage

>>> src/bc1_bc2_bc3_block_decoder.sv
// BC1/BC2/BC3 block decoder top: APB format register, front classifier,
// block queue, palette builder and pixel sequencer. Depends on bcd_pkg.
// The first pixel of a block passes the front register, the queue, palette
// stages 1 and 2, the block register and the output register. Its pixels follow
// one per cycle while out_ready_i is high, set by the single-pixel output stage.
// Reset: format returns to BC1, all stages and the queue come up empty.
module bc1_bc2_bc3_block_decoder import bcd_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_item_o
);

  format_e             format_q, format_d;
  logic [RegIdxW-1:0]  reg_idx;
  logic                fr_valid, fr_ready, qu_valid, qu_ready, pl_valid, pl_ready;
  blk_t                fr_blk, qu_blk;
  pblk_t               pl_blk;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];

  always_comb begin
    format_d = format_q;
    if (psel && penable && pwrite && (reg_idx == REG_FORMAT)) begin
      format_d = format_e'(pwdata[1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= FMT_BC1;
    end else begin
      format_q <= format_d;
    end
  end

  assign prdata = (reg_idx == REG_FORMAT) ? {30'd0, format_q} : 32'd0;

  bcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .format_i    (format_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_blk_o   (fr_blk)
  );

  bcd_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_blk_i    (fr_blk),
    .out_valid_o (qu_valid),
    .out_ready_i (qu_ready),
    .out_blk_o   (qu_blk)
  );

  bcd_palette u_palette (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (qu_valid),
    .in_ready_o  (qu_ready),
    .in_blk_i    (qu_blk),
    .out_valid_o (pl_valid),
    .out_ready_i (pl_ready),
    .out_blk_o   (pl_blk)
  );

  bcd_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pl_valid),
    .in_ready_o  (pl_ready),
    .in_blk_i    (pl_blk),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // pixels of a block come out in order with no gap once one is taken
  a_pixel_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_item_o.last_pixel) |=>
      (out_valid_o &&
       (out_item_o.pixel_index == $past(out_item_o.pixel_index) + 4'd1)))
    else $error("pixel sequence broken");

  // a stalled classified block is held until the queue takes it
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fr_valid && !fr_ready) |=> (fr_valid && $stable(fr_blk)))
    else $error("front block lost while stalled");

  // in BC1 only transparent black carries zero alpha
  a_bc1_transparent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (format_q == FMT_BC1) && (out_item_o.alpha == 8'h00)) |->
      ((out_item_o.red == 8'h00) && (out_item_o.green == 8'h00) &&
       (out_item_o.blue == 8'h00)))
    else $error("transparent pixel with color");

endmodule

>>> src/bcd_front.sv
// Front end: takes a compressed block, extracts endpoints and classifies the
// palette mode. One register stage. Depends on bcd_pkg.
module bcd_front import bcd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  format_e  format_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output blk_t     out_blk_o
);

  logic valid_q, valid_d;
  blk_t blk_q, blk_d;
  logic accept;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    blk_d.e0         = in_item_i.color_bits[15:0];
    blk_d.e1         = in_item_i.color_bits[31:16];
    blk_d.cidx       = in_item_i.color_bits[63:32];
    blk_d.abits      = in_item_i.alpha_bits;
    blk_d.mode.bc1   = (format_i == FMT_BC1);
    blk_d.mode.bc3   = (format_i == FMT_BC3) || (format_i == FMT_BC3X);
    blk_d.mode.three = blk_d.mode.bc1 && (blk_d.e0 <= blk_d.e1);
    blk_d.mode.a_gt  = in_item_i.alpha_bits[7:0] > in_item_i.alpha_bits[15:8];
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      blk_q <= blk_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_blk_o   = blk_q;

endmodule

>>> src/bcd_queue.sv
// Short block queue between front and back end, so either side can stall.
// Depends on bcd_pkg.
module bcd_queue import bcd_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  blk_t in_blk_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output blk_t out_blk_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  blk_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign in_ready_o  = (cnt_q != Full);
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_blk_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_blk_i;
    end
  end

endmodule

>>> src/bcd_palette.sv
// Palette builder: stage 1 forms numerators and picks reciprocals, stage 2
// multiplies out the rounded color and alpha palette entries.
// Depends on bcd_pkg.
module bcd_palette import bcd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  blk_t  in_blk_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output pblk_t out_blk_o
);

  typedef struct packed {
    mode_t                     mode;
    logic [31:0]               cidx;
    logic [63:0]               abits;
    logic [3:0][2:0][ColNW-1:0] col_n;
    logic [3:0][2:0][ColRW-1:0] col_r;
    logic [5:0][AlpNW-1:0]     alp_n;
    logic [AlpRW-1:0]          alp_r;
  } s1_t;

  logic  s1_valid_q, s2_valid_q;
  logic  s1_ready, s2_ready;
  s1_t   s1_q, s1_d;
  pblk_t s2_q, s2_d;

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // stage 1: numerators N = 510*v + D over divisor 2D
  always_comb begin
    logic [2:0][5:0] c0, c1;
    logic [7:0]      m, m2, m3, v;
    logic            wide;
    logic [10:0]     n;
    s1_d.mode  = in_blk_i.mode;
    s1_d.cidx  = in_blk_i.cidx;
    s1_d.abits = in_blk_i.abits;
    c0[0] = {1'b0, in_blk_i.e0[15:11]};
    c0[1] = in_blk_i.e0[10:5];
    c0[2] = {1'b0, in_blk_i.e0[4:0]};
    c1[0] = {1'b0, in_blk_i.e1[15:11]};
    c1[1] = in_blk_i.e1[10:5];
    c1[2] = {1'b0, in_blk_i.e1[4:0]};
    for (int k = 0; k < 3; k++) begin
      wide = (k == 1);
      m    = wide ? 8'd63 : 8'd31;
      m2   = {m[6:0], 1'b0};
      m3   = m2 + m;
      s1_d.col_n[0][k] = ColNW'(c0[k]) * ColNW'(510) + ColNW'(m);
      s1_d.col_r[0][k] = wide ? RCP_D63 : RCP_D31;
      s1_d.col_n[1][k] = ColNW'(c1[k]) * ColNW'(510) + ColNW'(m);
      s1_d.col_r[1][k] = wide ? RCP_D63 : RCP_D31;
      if (in_blk_i.mode.three) begin
        v = {2'b00, c0[k]} + {2'b00, c1[k]};
        s1_d.col_n[2][k] = ColNW'(v) * ColNW'(510) + ColNW'(m2);
        s1_d.col_r[2][k] = wide ? RCP_D126 : RCP_D62;
        s1_d.col_n[3][k] = '0;   // transparent black
        s1_d.col_r[3][k] = RCP_D93;
      end else begin
        v = {1'b0, c0[k], 1'b0} + {2'b00, c1[k]};
        s1_d.col_n[2][k] = ColNW'(v) * ColNW'(510) + ColNW'(m3);
        s1_d.col_r[2][k] = wide ? RCP_D189 : RCP_D93;
        v = {2'b00, c0[k]} + {1'b0, c1[k], 1'b0};
        s1_d.col_n[3][k] = ColNW'(v) * ColNW'(510) + ColNW'(m3);
        s1_d.col_r[3][k] = wide ? RCP_D189 : RCP_D93;
      end
    end
    // alpha entries 2..7
    s1_d.alp_r = in_blk_i.mode.a_gt ? RCP_A7 : RCP_A5;
    for (int j = 0; j < 6; j++) begin
      if (in_blk_i.mode.a_gt) begin
        n = 11'(in_blk_i.abits[7:0]) * 11'(6 - j) + 11'(in_blk_i.abits[15:8]) * 11'(j + 1);
        s1_d.alp_n[j] = {n, 1'b0} + AlpNW'(7);
      end else if (j < 4) begin
        n = 11'(in_blk_i.abits[7:0]) * 11'(4 - j) + 11'(in_blk_i.abits[15:8]) * 11'(j + 1);
        s1_d.alp_n[j] = {n, 1'b0} + AlpNW'(5);
      end else if (j == 4) begin
        n = '0;
        s1_d.alp_n[j] = '0;
      end else begin
        n = '0;
        s1_d.alp_n[j] = ALP_N_FULL;
      end
    end
  end

  // stage 2: one reciprocal multiply per entry
  always_comb begin
    logic [ColNW+ColRW-1:0] cprod;
    logic [AlpNW+AlpRW-1:0] aprod;
    s2_d.mode  = s1_q.mode;
    s2_d.cidx  = s1_q.cidx;
    s2_d.abits = s1_q.abits;
    for (int e = 0; e < 4; e++) begin
      for (int k = 0; k < 3; k++) begin
        cprod = (ColNW+ColRW)'(s1_q.col_n[e][k]) * (ColNW+ColRW)'(s1_q.col_r[e][k]);
        s2_d.pal.col[e][k] = cprod[ColShift +: 8];
      end
    end
    s2_d.pal.apal[0] = s1_q.abits[7:0];
    s2_d.pal.apal[1] = s1_q.abits[15:8];
    for (int j = 0; j < 6; j++) begin
      aprod = (AlpNW+AlpRW)'(s1_q.alp_n[j]) * (AlpNW+AlpRW)'(s1_q.alp_r);
      s2_d.pal.apal[j+2] = aprod[AlpShift +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_q <= s1_d;
    end
    if (s1_valid_q && s2_ready) begin
      s2_q <= s2_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_blk_o   = s2_q;

endmodule

>>> src/bcd_emit.sv
// Pixel sequencer: walks the sixteen pixels of a decoded block, one per
// cycle while the output is not stalled, into a registered output. Depends on bcd_pkg.
module bcd_emit import bcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pblk_t     in_blk_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  pblk_t      cur_q;
  logic       cur_valid_q, cur_valid_d;
  logic [3:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;
  logic       adv, last, load;

  assign adv        = cur_valid_q && (!out_valid_q || out_ready_i);
  assign last       = (cnt_q == 4'hF);
  assign in_ready_o = !cur_valid_q || (adv && last);
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    logic [1:0] ci;
    logic [5:0] aoff;
    logic [2:0] ai;
    logic [3:0] nib;
    ci   = cur_q.cidx[{cnt_q, 1'b0} +: 2];
    aoff = {2'b00, cnt_q} + {1'b0, cnt_q, 1'b0};
    ai   = cur_q.abits[16 + aoff +: 3];
    nib  = cur_q.abits[{cnt_q, 2'b00} +: 4];
    out_d.red         = cur_q.pal.col[ci][0];
    out_d.green       = cur_q.pal.col[ci][1];
    out_d.blue        = cur_q.pal.col[ci][2];
    out_d.pixel_index = cnt_q;
    out_d.last_pixel  = last;
    if (cur_q.mode.bc1) begin
      out_d.alpha = (cur_q.mode.three && (ci == 2'd3)) ? 8'h00 : 8'hFF;
    end else if (cur_q.mode.bc3) begin
      out_d.alpha = cur_q.pal.apal[ai];
    end else begin
      out_d.alpha = {nib, nib};
    end
  end

  always_comb begin
    cur_valid_d = cur_valid_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      cnt_d       = cnt_q + 4'd1;   // wraps to zero after the last pixel
      out_valid_d = 1'b1;
      if (last) begin
        cur_valid_d = 1'b0;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      cur_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= in_blk_i;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> sim/tb_bc1_bc2_bc3_block_decoder.sv
`timescale 1ns / 1ps
// Self-checking testbench for bc1_bc2_bc3_block_decoder: drives blocks in all
// formats, predicts the 16 pixels of each one and checks them in order.
// Depends on bcd_pkg and the decoder RTL.
module tb_bc1_bc2_bc3_block_decoder;
  import bcd_pkg::*;

  localparam int unsigned IdleLimit      = 5000;
  localparam int unsigned SettleCycles   = 24;
  localparam int unsigned PhaseCount     = 9;
  localparam int unsigned RandomPerPhase = 37;
  localparam int unsigned MaxReports     = 10;
  localparam logic [AddrW-1:0] FormatAddr   = AddrW'(4 * REG_FORMAT);
  localparam logic [AddrW-1:0] UnmappedAddr = AddrW'(4);

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [AddrW-1:0] paddr       = '0;
  logic [31:0]      pwdata      = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  in_item_t         in_item_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_item_t        out_item_o;

  bc1_bc2_bc3_block_decoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #6 clk_i = ~clk_i;

  format_e     decode_format = FMT_BC1;
  in_item_t    block_queue[$];
  out_item_t   expected_pixels[$];
  out_item_t   want_pixel;
  int unsigned blocks_queued   = 0;
  int unsigned blocks_accepted = 0;
  int unsigned pixels_checked  = 0;
  int unsigned pixel_errors    = 0;
  int unsigned send_gap        = 0;
  int unsigned stall_left      = 0;
  int unsigned idle_cycles     = 0;
  bit          throttle        = 1'b1;
  bit [3:0]    formats_seen    = '0;

  // Round half up of n/d, clipped to 255.
  function automatic logic [7:0] round_div(int unsigned n, int unsigned d);
    int unsigned q;
    q = (2 * n + d) / (2 * d);
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // Mostly short gaps, now and then a long one; none when throttling is off.
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!throttle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t random_block();
    in_item_t b;
    b.alpha_bits = {$urandom, $urandom};
    b.color_bits = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: b.color_bits[31:16] = b.color_bits[15:0];
      1: b.color_bits[15:0]  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      2: b.color_bits[31:16] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: b.alpha_bits[15:8] = b.alpha_bits[7:0];
      1: b.alpha_bits[7:0]  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2: b.alpha_bits[15:8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: ;
    endcase
    return b;
  endfunction

  // Expected pixels of one block under the current format.
  task automatic predict_pixels(in_item_t blk);
    int unsigned c0[3];
    int unsigned c1[3];
    int unsigned full[3];
    logic [7:0]  pal[4][4];
    logic [7:0]  apal[8];
    int unsigned a0, a1, ci;
    bit          bc1, bc3, three;
    out_item_t   px;
    bc1   = (decode_format == FMT_BC1);
    bc3   = decode_format[1];
    three = bc1 && (blk.color_bits[15:0] <= blk.color_bits[31:16]);
    c0[0] = blk.color_bits[15:11];
    c0[1] = blk.color_bits[10:5];
    c0[2] = blk.color_bits[4:0];
    c1[0] = blk.color_bits[31:27];
    c1[1] = blk.color_bits[26:21];
    c1[2] = blk.color_bits[20:16];
    full  = '{31, 63, 31};
    for (int k = 0; k < 3; k++) begin
      pal[0][k] = round_div(c0[k] * 255, full[k]);
      pal[1][k] = round_div(c1[k] * 255, full[k]);
      if (three) begin
        pal[2][k] = round_div((c0[k] + c1[k]) * 255, 2 * full[k]);
        pal[3][k] = 8'd0;
      end else begin
        pal[2][k] = round_div((2 * c0[k] + c1[k]) * 255, 3 * full[k]);
        pal[3][k] = round_div((c0[k] + 2 * c1[k]) * 255, 3 * full[k]);
      end
    end
    pal[0][3] = 8'd255;
    pal[1][3] = 8'd255;
    pal[2][3] = 8'd255;
    pal[3][3] = three ? 8'd0 : 8'd255;

    a0 = blk.alpha_bits[7:0];
    a1 = blk.alpha_bits[15:8];
    apal[0] = a0[7:0];
    apal[1] = a1[7:0];
    if (a0 > a1) begin
      for (int k = 1; k < 7; k++) apal[k + 1] = round_div(a0 * (7 - k) + a1 * k, 7);
    end else begin
      for (int k = 1; k < 5; k++) apal[k + 1] = round_div(a0 * (5 - k) + a1 * k, 5);
      apal[6] = 8'd0;
      apal[7] = 8'd255;
    end

    for (int i = 0; i < 16; i++) begin
      ci        = blk.color_bits[32 + 2 * i +: 2];
      px.red    = pal[ci][0];
      px.green  = pal[ci][1];
      px.blue   = pal[ci][2];
      if (bc1)
        px.alpha = pal[ci][3];
      else if (bc3)
        px.alpha = apal[blk.alpha_bits[16 + 3 * i +: 3]];
      else
        px.alpha = 8'(blk.alpha_bits[4 * i +: 4] * 17);
      px.pixel_index = 4'(i);
      px.last_pixel  = (i == 15);
      expected_pixels.push_back(px);
    end
  endtask

  // Block driver: takes items from block_queue, random gaps between transfers.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_pixels(in_item_i);
        blocks_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (block_queue.size() != 0) begin
          in_item_i  <= block_queue.pop_front();
          in_valid_i <= 1'b1;
          send_gap = draw_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor and output backpressure.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        pixels_checked++;
        if (expected_pixels.size() == 0) begin
          pixel_errors++;
          if (pixel_errors <= MaxReports)
            $display("ERROR: pixel with nothing expected: idx %0d rgba %h %h %h %h",
                     out_item_o.pixel_index, out_item_o.red, out_item_o.green,
                     out_item_o.blue, out_item_o.alpha);
        end else begin
          want_pixel = expected_pixels.pop_front();
          if (out_item_o.red !== want_pixel.red || out_item_o.green !== want_pixel.green ||
              out_item_o.blue !== want_pixel.blue || out_item_o.alpha !== want_pixel.alpha ||
              out_item_o.pixel_index !== want_pixel.pixel_index ||
              out_item_o.last_pixel !== want_pixel.last_pixel) begin
            pixel_errors++;
            if (pixel_errors <= MaxReports)
              $display({"ERROR: pixel mismatch: exp idx %0d last %0d rgba %h %h %h %h,",
                        " got idx %0d last %0d rgba %h %h %h %h"},
                       want_pixel.pixel_index, want_pixel.last_pixel, want_pixel.red,
                       want_pixel.green, want_pixel.blue, want_pixel.alpha,
                       out_item_o.pixel_index, out_item_o.last_pixel, out_item_o.red,
                       out_item_o.green, out_item_o.blue, out_item_o.alpha);
          end
        end
      end
      if (stall_left != 0) stall_left--;
      else if ($urandom_range(0, 3) == 0) stall_left = draw_gap();
      out_ready_i <= (stall_left == 0);
    end
  end

  // Watchdog: cycles with work outstanding but no transfer on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles = 0;
      else if (blocks_queued != blocks_accepted || expected_pixels.size() != 0)
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("ERROR: no transfer for %0d cycles", IdleLimit);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [AddrW-1:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == FormatAddr) decode_format = format_e'(data[1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic queue_block(logic [63:0] alpha, logic [63:0] color);
    block_queue.push_back({alpha, color});
    blocks_queued++;
  endtask

  task automatic wait_idle();
    while (blocks_accepted != blocks_queued || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [47:0] alpha_ramp;
    logic [31:0] wdata;
    format_e     fmt;
    in_item_t    rnd;
    for (int k = 0; k < 16; k++) alpha_ramp[3 * k +: 3] = 3'(k % 8);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < PhaseCount; ph++) begin
      fmt      = (ph < 4) ? format_e'(ph) : format_e'($urandom_range(0, 3));
      throttle = (ph != 2 && ph != 6);
      wdata    = (ph < 4) ? 32'(fmt) : {$urandom};
      wdata[1:0] = fmt;
      write_reg(FormatAddr, wdata);
      if (ph == 5) write_reg(UnmappedAddr, $urandom);  // unmapped: must not touch format
      formats_seen[decode_format] = 1'b1;

      case (ph)
        0: begin
          queue_block({$urandom, $urandom}, {32'hE4E4E4E4, 16'h0000, 16'hFFFF});
          queue_block({$urandom, $urandom}, {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
          queue_block('0, {32'h1B1B1B1B, 16'h1234, 16'h1234});
          queue_block('0, {32'hE4E4E4E4, 16'h07E0, 16'hF800});
          queue_block('0, {32'h4E4E4E4E, 16'hF81F, 16'h001F});
          queue_block('1, '1);
          queue_block('0, '0);
        end
        1: begin
          queue_block(64'hFEDCBA9876543210, {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
          queue_block(64'h0123456789ABCDEF, {32'hE4E4E4E4, 16'h0000, 16'hFFFF});
          queue_block('1, {$urandom, $urandom});
          queue_block('0, {$urandom, $urandom});
        end
        2: begin
          queue_block({alpha_ramp, 8'h00, 8'hFF}, {32'hE4E4E4E4, 16'h0000, 16'hFFFF});
          queue_block({alpha_ramp, 8'hFF, 8'h00}, {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
          queue_block({alpha_ramp, 8'h80, 8'h80}, {$urandom, $urandom});
          queue_block({alpha_ramp, 8'h00, 8'h00}, {$urandom, $urandom});
          queue_block({alpha_ramp, 8'hFF, 8'hFF}, {$urandom, $urandom});
          queue_block({alpha_ramp, 8'h10, 8'hF3}, {$urandom, $urandom});
        end
        3: begin
          queue_block({alpha_ramp, 8'h20, 8'hC8}, {$urandom, $urandom});
          queue_block({alpha_ramp, 8'hC8, 8'h20}, {$urandom, $urandom});
        end
        default: ;
      endcase

      repeat (RandomPerPhase) begin
        rnd = random_block();
        queue_block(rnd.alpha_bits, rnd.color_bits);
      end
      wait_idle();
    end

    if (expected_pixels.size() != 0) pixel_errors += expected_pixels.size();
    $display("Run covered %0d blocks and %0d pixels over %0d format settings (codes seen %b),",
             blocks_accepted, pixels_checked, PhaseCount, formats_seen);
    $display("with random gaps and stalls on both channels; %0d pixel errors.", pixel_errors);
    if (pixel_errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
src/bcd_pkg.sv
src/bcd_front.sv
src/bcd_queue.sv
src/bcd_palette.sv
src/bcd_emit.sv
src/bc1_bc2_bc3_block_decoder.sv
sim/tb_bc1_bc2_bc3_block_decoder.sv
